>>> hw/rtl/lbp_3x3_image_filter_defines.svh
// Assertion macros for the 3x3 local binary pattern filter.
`ifndef LBP_3X3_IMAGE_FILTER_DEFINES_SVH
`define LBP_3X3_IMAGE_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
`define LBP3_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LBP3_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LBP3_ASSERT(label, prop, msg)
`define LBP3_ASSERT_NEVER(label, cond, msg)
`endif

`endif

>>> hw/rtl/lbp3_pkg.sv
// Shared constants and types of the 3x3 local binary pattern filter.
`default_nettype none

package lbp3_pkg;

    localparam int PIXEL_W         = 8;
    localparam int IMAGE_WIDTH_W   = 11;
    localparam int IMAGE_HEIGHT_W  = 13;
    localparam int ROW_W           = 13;
    localparam int CFG_INDEX_W     = 4;
    localparam int CFG_DATA_W      = 13;

    localparam int MAX_WIDTH_DFLT  = 1024;
    localparam int DEFAULT_WIDTH   = 512;
    localparam int DEFAULT_HEIGHT  = 512;
    localparam int HEIGHT_LIMIT    = 4096;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Which neighbours of the output pixel lie inside the image
    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
    } lbp3_bounds_t;

endpackage

`default_nettype wire

>>> hw/rtl/lbp3_if.sv
// Stream and configuration channel interfaces of the 3x3 local binary pattern filter.
`default_nettype none

interface lbp3_pixel_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] pixel_value;

    modport source (output valid, output opcode, output pixel_value, input ready);
    modport sink (input valid, input opcode, input pixel_value, output ready);
endinterface

interface lbp3_code_if;
    logic       valid;
    logic       ready;
    logic [7:0] lbp_code;
    logic       last_of_frame;

    modport source (output valid, output lbp_code, output last_of_frame, input ready);
    modport sink (input valid, input lbp_code, input last_of_frame, output ready);
endinterface

interface lbp3_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [12:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lbp3_window.sv
// 3x3 neighbour window and pattern comparators of the local binary pattern filter.
`default_nettype none

module lbp3_window (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  shift,
    input  logic                  clear,
    input  logic [7:0]            top_px,
    input  logic [7:0]            mid_px,
    input  logic [7:0]            bot_px,
    input  lbp3_pkg::lbp3_bounds_t bounds,
    output logic [7:0]            code
);
    import lbp3_pkg::*;

    logic [PIXEL_W-1:0] win_reg  [9];
    logic [PIXEL_W-1:0] win_next [9];
    logic [PIXEL_W-1:0] center;

    // Shift each row left by one and take the new right column
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r*3]     = win_reg[r*3 + 1];
            win_next[r*3 + 1] = win_reg[r*3 + 2];
        end
        win_next[2] = top_px;
        win_next[5] = mid_px;
        win_next[8] = bot_px;
    end

    assign center = win_next[4];

    always_comb
    begin
        code[0] = bounds.up && bounds.left && (win_next[0] >= center);
        code[1] = bounds.up && (win_next[1] >= center);
        code[2] = bounds.up && bounds.right && (win_next[2] >= center);
        code[3] = bounds.left && (win_next[3] >= center);
        code[4] = bounds.right && (win_next[5] >= center);
        code[5] = bounds.down && bounds.left && (win_next[6] >= center);
        code[6] = bounds.down && (win_next[7] >= center);
        code[7] = bounds.down && bounds.right && (win_next[8] >= center);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (clear)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (shift)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lbp_3x3_image_filter.sv
// Top level of the streaming 3x3 local binary pattern filter.
// Throughput: one item per clock; a stalled output backs up the input after two items.
// Latency: width+1 items from pixel to code; the code is loaded into the output register
// once the item completing its neighbourhood has passed the row memory read and the compare.
// Reset: width and height go to 512, raster position and window to zero; the row memory
// holds no reset and its stale entries only feed masked out-of-image neighbours.
`default_nettype none

`include "lbp_3x3_image_filter_defines.svh"

module lbp_3x3_image_filter #(
    parameter int MAX_WIDTH = lbp3_pkg::MAX_WIDTH_DFLT
) (
    input  logic         clk,
    input  logic         rst_n,
    lbp3_pixel_if.sink   pixel_in,
    lbp3_code_if.source  code_out,
    lbp3_cfg_if.sink     cfg
);
    import lbp3_pkg::*;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int CMP_W   = (IMAGE_WIDTH_W > COL_W + 1) ? IMAGE_WIDTH_W : COL_W + 1;
    localparam int RESET_W = (DEFAULT_WIDTH > MAX_WIDTH) ? MAX_WIDTH : DEFAULT_WIDTH;
    localparam logic [COL_W-1:0] RESET_WIDTH_M1 = COL_W'(RESET_W - 1);

    // ------------------------------------------------------------------
    // Configuration: store the clamped width (minus one) and height.
    // Any write restarts the frame.
    // ------------------------------------------------------------------
    logic                      cfg_wr;
    logic [CMP_W-1:0]          cfg_width_ext;
    logic [COL_W-1:0]          cfg_width_m1;
    logic [IMAGE_HEIGHT_W-1:0] cfg_height_raw;
    logic [IMAGE_HEIGHT_W-1:0] cfg_height;
    logic [COL_W-1:0]          width_m1_reg;
    logic [ROW_W-1:0]          height_reg;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;

    always_comb
    begin
        cfg_width_ext  = CMP_W'(cfg.data[IMAGE_WIDTH_W-1:0]);
        cfg_height_raw = cfg.data[IMAGE_HEIGHT_W-1:0];
        if (cfg_width_ext < CMP_W'(2))
        begin
            cfg_width_m1 = COL_W'(1);
        end
        else if (cfg_width_ext > CMP_W'(MAX_WIDTH))
        begin
            cfg_width_m1 = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            cfg_width_m1 = COL_W'(cfg_width_ext - CMP_W'(1));
        end
        if (cfg_height_raw < IMAGE_HEIGHT_W'(2))
        begin
            cfg_height = IMAGE_HEIGHT_W'(2);
        end
        else if (cfg_height_raw > IMAGE_HEIGHT_W'(HEIGHT_LIMIT))
        begin
            cfg_height = IMAGE_HEIGHT_W'(HEIGHT_LIMIT);
        end
        else
        begin
            cfg_height = cfg_height_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_m1_reg <= RESET_WIDTH_M1;
            height_reg   <= ROW_W'(DEFAULT_HEIGHT);
        end
        else if (cfg_wr)
        begin
            unique case (cfg.index)
                REG_IMAGE_WIDTH:  width_m1_reg <= cfg_width_m1;
                REG_IMAGE_HEIGHT: height_reg   <= ROW_W'(cfg_height);
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: accept the item, track the raster position, issue the
    // row memory read at the current column.
    // ------------------------------------------------------------------
    logic               in_ready;
    logic               accept;
    logic               tail;
    logic               drop;
    logic               step;
    logic               col_nz;
    logic               s0_emit;
    logic               s0_last;
    lbp3_bounds_t       s0_bounds;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;

    logic               s1_valid_reg;
    logic               s1_adv;
    logic [COL_W-1:0]   s1_col_reg;
    logic [PIXEL_W-1:0] s1_pix_reg;
    logic               s1_emit_reg;
    logic               s1_last_reg;
    lbp3_bounds_t       s1_bounds_reg;
    logic [2*PIXEL_W-1:0] mem_rd_reg;

    logic               out_valid_reg;
    logic [PIXEL_W-1:0] out_code_reg;
    logic               out_last_reg;
    logic [PIXEL_W-1:0] win_code;

    assign in_ready       = !s1_valid_reg || s1_adv;
    assign pixel_in.ready = in_ready;
    assign accept         = pixel_in.valid && in_ready;

    // Rows at or past the height are the tail: every item acts as a drain there
    assign tail   = row_reg >= height_reg;
    // Drop a drain that arrives before the tail
    assign drop   = (pixel_in.opcode == OP_DRAIN) && !tail;
    assign step   = accept && !drop;
    assign col_nz = col_reg != '0;

    // The output pixel is one column back, or the row end two rows up when at column zero
    assign s0_emit = (row_reg >= ROW_W'(2)) || ((row_reg == ROW_W'(1)) && col_nz);
    // Final pixel of the frame leaves with the first item of row height+1
    assign s0_last = (row_reg == height_reg + ROW_W'(1)) && !col_nz;

    always_comb
    begin
        s0_bounds.up    = col_nz ? (row_reg >= ROW_W'(2)) : (row_reg >= ROW_W'(3));
        s0_bounds.down  = col_nz ? (row_reg < height_reg) : (row_reg <= height_reg);
        s0_bounds.left  = col_reg != COL_W'(1);
        s0_bounds.right = col_nz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_wr || (step && s0_last))
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (step)
        begin
            if (col_reg == width_m1_reg)
            begin
                col_reg <= '0;
                row_reg <= row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Row memory: each entry holds {two rows back, one row back} for a
    // column. Read at acceptance, written back one stage later. Within a
    // frame the next access to the same column is at least two items
    // later, so the write always lands before that read. At the frame
    // wrap the first item of the new frame reads column zero while the
    // final item writes it; that read only feeds masked top-row neighbours.
    // ------------------------------------------------------------------
    logic [2*PIXEL_W-1:0] row_mem [MAX_WIDTH];

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            row_mem[s1_col_reg] <= {mem_rd_reg[PIXEL_W-1:0], s1_pix_reg};
        end
        if (step)
        begin
            mem_rd_reg <= row_mem[col_reg];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: shift the window, compare, load the output register.
    // Advance when the item gives no code or the output slot is free.
    // ------------------------------------------------------------------
    assign s1_adv = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || code_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            s1_col_reg    <= col_reg;
            s1_pix_reg    <= tail ? '0 : pixel_in.pixel_value;
            s1_emit_reg   <= s0_emit;
            s1_last_reg   <= s0_last;
            s1_bounds_reg <= s0_bounds;
        end
    end

    lbp3_window u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .shift  (s1_adv),
        .clear  (cfg_wr || (s1_adv && s1_last_reg)),
        .top_px (mem_rd_reg[2*PIXEL_W-1:PIXEL_W]),
        .mid_px (mem_rd_reg[PIXEL_W-1:0]),
        .bot_px (s1_pix_reg),
        .bounds (s1_bounds_reg),
        .code   (win_code)
    );

    // Output register: hold the code until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_emit_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (code_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_emit_reg)
        begin
            out_code_reg <= win_code;
            out_last_reg <= s1_last_reg;
        end
    end

    assign code_out.valid         = out_valid_reg;
    assign code_out.lbp_code      = out_code_reg;
    assign code_out.last_of_frame = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LBP3_ASSERT_NEVER(a_col_collision, s1_adv && step && !s1_last_reg && (s1_col_reg == col_reg), "row memory read and write hit the same column")
    `LBP3_ASSERT(a_frame_restart, (step && s0_last) |=> (col_reg == '0 && row_reg == '0), "raster position not cleared after final pixel")
    `LBP3_ASSERT(a_col_in_range, col_reg <= width_m1_reg, "column position beyond image width")

endmodule

`default_nettype wire
